@@ rtl/mandelbrot_escape_pixel_macros.svh @@
// Assertion macros used by the Mandelbrot pixel queue.
`ifndef MANDELBROT_ESCAPE_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_PIXEL_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define MEP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence on the next edge.
`define MEP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/mep_pkg.sv @@
// Shared types and constants of the Mandelbrot pixel block.
package mep_pkg;
    localparam int MEP_MAX_DIM   = 4096;
    localparam int MEP_FRAC_BITS = 60;

    typedef enum logic [2:0] {
        CFG_MIN_REAL  = 3'd0,
        CFG_MAX_REAL  = 3'd1,
        CFG_MIN_IMAG  = 3'd2,
        CFG_MAX_IMAG  = 3'd3,
        CFG_WIDTH     = 3'd4,
        CFG_HEIGHT    = 3'd5,
        CFG_ITER_LIM  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [63:0] cr;
        logic [63:0] ci;
    } t_coord;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;
endpackage

@@ rtl/mep_front.sv @@
// Front end: accepts a pixel and maps it onto the complex window.
module mep_front
    import mep_pkg::*;
#(
    parameter int MAX_DIM = MEP_MAX_DIM
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [11:0] i_pixel_col,
    input  logic [11:0] i_pixel_row,
    input  logic [63:0] i_min_real,
    input  logic [63:0] i_max_real,
    input  logic [63:0] i_min_imag,
    input  logic [63:0] i_max_imag,
    input  logic [12:0] i_image_width,
    input  logic [12:0] i_image_height,
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_coord      o_coord
);
    localparam int DimCap = (MAX_DIM < 8191) ? MAX_DIM : 8191;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_MUL  = 5'b00010,
        F_DIV  = 5'b00100,
        F_SUM  = 5'b01000,
        F_PUSH = 5'b10000
    } t_fstate;

    t_fstate     r_state, n_state;
    logic [11:0] r_col, n_col, r_row, n_row;
    logic [76:0] r_dd_r, n_dd_r, r_dd_i, n_dd_i;
    logic [13:0] r_rem_r, n_rem_r, r_rem_i, n_rem_i;
    logic        r_neg_r, n_neg_r, r_neg_i, n_neg_i;
    logic [6:0]  r_cnt, n_cnt;
    t_coord      r_out, n_out;

    logic [12:0] w_dw, w_dh, w_div_r, w_div_i;
    logic [64:0] w_span_r, w_span_i, w_mag_r, w_mag_i;
    logic [13:0] w_t_r, w_t_i;
    logic [78:0] w_q_r, w_q_i, w_s_r, w_s_i;

    function automatic logic [12:0] clamp_dim(input logic [12:0] d);
        logic [12:0] v;
        v = d;
        if (v < 13'd2) v = 13'd2;
        if (v > 13'(DimCap)) v = 13'(DimCap);
        return v;
    endfunction

    function automatic logic [63:0] sat64(input logic [78:0] s);
        logic [63:0] v;
        if (s[78:63] == {16{s[63]}}) v = s[63:0];
        else if (s[78]) v = {1'b1, 63'd0};
        else v = {1'b0, {63{1'b1}}};
        return v;
    endfunction

    always_comb begin
        w_dw     = clamp_dim(i_image_width);
        w_dh     = clamp_dim(i_image_height);
        w_div_r  = w_dw - 13'd1;
        w_div_i  = w_dh - 13'd1;
        w_span_r = {i_max_real[63], i_max_real} - {i_min_real[63], i_min_real};
        w_span_i = {i_max_imag[63], i_max_imag} - {i_min_imag[63], i_min_imag};
        w_mag_r  = w_span_r[64] ? (65'd0 - w_span_r) : w_span_r;
        w_mag_i  = w_span_i[64] ? (65'd0 - w_span_i) : w_span_i;
        w_t_r    = {r_rem_r[12:0], r_dd_r[76]};
        w_t_i    = {r_rem_i[12:0], r_dd_i[76]};
        w_q_r    = r_neg_r ? (79'd0 - {2'b00, r_dd_r}) : {2'b00, r_dd_r};
        w_q_i    = r_neg_i ? (79'd0 - {2'b00, r_dd_i}) : {2'b00, r_dd_i};
        w_s_r    = {{15{i_min_real[63]}}, i_min_real} + w_q_r;
        w_s_i    = {{15{i_min_imag[63]}}, i_min_imag} + w_q_i;
    end

    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_row   = r_row;
        n_dd_r  = r_dd_r;
        n_dd_i  = r_dd_i;
        n_rem_r = r_rem_r;
        n_rem_i = r_rem_i;
        n_neg_r = r_neg_r;
        n_neg_i = r_neg_i;
        n_cnt   = r_cnt;
        n_out   = r_out;
        case (r_state)
            F_IDLE: begin
                if (i_in_valid) begin
                    n_col   = i_pixel_col;
                    n_row   = i_pixel_row;
                    n_state = F_MUL;
                end
            end
            F_MUL: begin
                n_dd_r  = 77'(w_mag_r * {65'd0, r_col});
                n_dd_i  = 77'(w_mag_i * {65'd0, r_row});
                n_neg_r = w_span_r[64];
                n_neg_i = w_span_i[64];
                n_rem_r = '0;
                n_rem_i = '0;
                n_cnt   = '0;
                n_state = F_DIV;
            end
            F_DIV: begin
                if (w_t_r >= {1'b0, w_div_r}) begin
                    n_rem_r = w_t_r - {1'b0, w_div_r};
                    n_dd_r  = {r_dd_r[75:0], 1'b1};
                end else begin
                    n_rem_r = w_t_r;
                    n_dd_r  = {r_dd_r[75:0], 1'b0};
                end
                if (w_t_i >= {1'b0, w_div_i}) begin
                    n_rem_i = w_t_i - {1'b0, w_div_i};
                    n_dd_i  = {r_dd_i[75:0], 1'b1};
                end else begin
                    n_rem_i = w_t_i;
                    n_dd_i  = {r_dd_i[75:0], 1'b0};
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd76) n_state = F_SUM;
            end
            F_SUM: begin
                n_out.cr = sat64(w_s_r);
                n_out.ci = sat64(w_s_i);
                n_state  = F_PUSH;
            end
            F_PUSH: begin
                if (!i_q_stat.full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_col   <= n_col;
        r_row   <= n_row;
        r_dd_r  <= n_dd_r;
        r_dd_i  <= n_dd_i;
        r_rem_r <= n_rem_r;
        r_rem_i <= n_rem_i;
        r_neg_r <= n_neg_r;
        r_neg_i <= n_neg_i;
        r_cnt   <= n_cnt;
        r_out   <= n_out;
    end

    assign o_in_stall = (r_state != F_IDLE);
    assign o_push     = (r_state == F_PUSH) && !i_q_stat.full;
    assign o_coord    = r_out;
endmodule

@@ rtl/mep_queue.sv @@
// Two-word queue between the front end and the iteration engine.
module mep_queue
    import mep_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_coord  i_data,
    input  logic    i_pop,
    output t_coord  o_data,
    output t_q_stat o_stat
);
    `include "mandelbrot_escape_pixel_macros.svh"

    t_coord     r_mem [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;

    always_comb begin
        n_wp  = i_push ? ~r_wp : r_wp;
        n_rp  = i_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt;
        if (i_push && !i_pop) n_cnt = r_cnt + 2'd1;
        if (!i_push && i_pop) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    `MEP_ASSERT(a_no_overflow, !(i_push && r_cnt == 2'd2), "Push into a full queue.")
    `MEP_ASSERT(a_no_underflow, !(i_pop && r_cnt == 2'd0), "Pop from an empty queue.")
    `MEP_ASSERT(a_cnt_range, r_cnt != 2'd3, "Queue count out of range.")
    `MEP_ASSERT_NEXT(a_cnt_grow, i_push && !i_pop, r_cnt == $past(r_cnt) + 2'd1, "Count missed a push.")
endmodule

@@ rtl/mep_back.sv @@
// Back end: iterates z = z^2 + c, then turns the count into a color.
module mep_back
    import mep_pkg::*;
#(
    parameter int FRAC_BITS = MEP_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_stat     i_q_stat,
    input  t_coord      i_coord,
    output logic        o_pop,
    input  logic [15:0] i_iteration_limit,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_escape_count,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue
);
    localparam logic [127:0] Four = 128'(1) << (2 * FRAC_BITS + 2);

    typedef enum logic [7:0] {
        B_IDLE = 8'b00000001,
        B_MUL  = 8'b00000010,
        B_STEP = 8'b00000100,
        B_LSET = 8'b00001000,
        B_LDIV = 8'b00010000,
        B_COL1 = 8'b00100000,
        B_COL2 = 8'b01000000,
        B_HOLD = 8'b10000000
    } t_bstate;

    t_bstate      r_state, n_state;
    logic [63:0]  r_cr, n_cr, r_ci, n_ci, r_zr, n_zr, r_zi, n_zi;
    logic [15:0]  r_n, n_n, r_lim, n_lim;
    logic [2:0]   r_ph, n_ph;
    logic [63:0]  r_p_sr, n_p_sr, r_p_si, n_p_si, r_p_p, n_p_p;
    logic [127:0] r_sr, n_sr, r_si, n_si, r_pp, n_pp;
    logic [23:0]  r_dd, n_dd;
    logic [16:0]  r_rem, n_rem;
    logic [4:0]   r_dcnt, n_dcnt;
    logic [7:0]   r_level, n_level;
    logic [13:0]  r_cprod, n_cprod;
    logic [2:0]   r_sect, n_sect;
    logic         r_ovalid, n_ovalid;
    logic [15:0]  r_o_cnt, n_o_cnt;
    logic [7:0]   r_o_r, n_o_r, r_o_g, n_o_g, r_o_b, n_o_b;
    logic [7:0]   r_c_r, n_c_r, r_c_g, n_c_g, r_c_b, n_c_b;

    logic [63:0]  w_mr, w_mi, w_zr_next, w_zi_next;
    logic [31:0]  w_ra, w_rb, w_ia, w_ib;
    logic [1:0]   w_kp;
    logic [127:0] w_sum, w_diff, w_pfull;
    logic         w_esc;
    logic [16:0]  w_dt;
    logic [7:0]   w_q120;
    logic [5:0]   w_t;
    logic [28:0]  w_xprod;
    logic [7:0]   w_x;

    function automatic logic [127:0] place(input logic [63:0] p, input logic [1:0] k);
        logic [127:0] v;
        case (k)
            2'd0: v = {64'd0, p};
            2'd3: v = {p, 64'd0};
            default: v = {32'd0, p, 32'd0};
        endcase
        return v;
    endfunction

    always_comb begin
        w_mr      = r_zr[63] ? (64'd0 - r_zr) : r_zr;
        w_mi      = r_zi[63] ? (64'd0 - r_zi) : r_zi;
        w_ra      = r_ph[1] ? w_mr[63:32] : w_mr[31:0];
        w_rb      = r_ph[0] ? w_mr[63:32] : w_mr[31:0];
        w_ia      = r_ph[1] ? w_mi[63:32] : w_mi[31:0];
        w_ib      = r_ph[0] ? w_mi[63:32] : w_mi[31:0];
        w_kp      = 2'(r_ph - 3'd1);
        w_sum     = r_sr + r_si;
        w_esc     = w_sum > Four;
        w_diff    = r_sr - r_si;
        w_pfull   = (r_zr[63] ^ r_zi[63]) ? (128'd0 - r_pp) : r_pp;
        w_zr_next = w_diff[FRAC_BITS+63:FRAC_BITS] + r_cr;
        w_zi_next = w_pfull[FRAC_BITS+62:FRAC_BITS-1] + r_ci;
        w_dt      = {r_rem[15:0], r_dd[23]};
        if (r_level >= 8'd240) w_q120 = r_level - 8'd240;
        else if (r_level >= 8'd120) w_q120 = r_level - 8'd120;
        else w_q120 = r_level;
        w_t       = (w_q120 > 8'd60) ? 6'(w_q120 - 8'd60) : 6'(8'd60 - w_q120);
        w_xprod   = {15'd0, r_cprod} * 29'd17477;
        w_x       = w_xprod[27:20];
    end

    always_comb begin
        n_state  = r_state;
        n_cr     = r_cr;
        n_ci     = r_ci;
        n_zr     = r_zr;
        n_zi     = r_zi;
        n_n      = r_n;
        n_lim    = r_lim;
        n_ph     = r_ph;
        n_p_sr   = r_p_sr;
        n_p_si   = r_p_si;
        n_p_p    = r_p_p;
        n_sr     = r_sr;
        n_si     = r_si;
        n_pp     = r_pp;
        n_dd     = r_dd;
        n_rem    = r_rem;
        n_dcnt   = r_dcnt;
        n_level  = r_level;
        n_cprod  = r_cprod;
        n_sect   = r_sect;
        n_ovalid = r_ovalid && i_out_stall;
        n_o_cnt  = r_o_cnt;
        n_o_r    = r_o_r;
        n_o_g    = r_o_g;
        n_o_b    = r_o_b;
        n_c_r    = r_c_r;
        n_c_g    = r_c_g;
        n_c_b    = r_c_b;
        o_pop    = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_cr    = i_coord.cr;
                    n_ci    = i_coord.ci;
                    n_zr    = i_coord.cr;
                    n_zi    = i_coord.ci;
                    n_n     = '0;
                    n_lim   = (i_iteration_limit == 16'd0) ? 16'd1 : i_iteration_limit;
                    n_ph    = '0;
                    n_sr    = '0;
                    n_si    = '0;
                    n_pp    = '0;
                    n_state = B_MUL;
                end
            end
            B_MUL: begin
                if (r_ph != 3'd4) begin
                    n_p_sr = {32'd0, w_ra} * {32'd0, w_rb};
                    n_p_si = {32'd0, w_ia} * {32'd0, w_ib};
                    n_p_p  = {32'd0, w_ra} * {32'd0, w_ib};
                end
                if (r_ph != 3'd0) begin
                    n_sr = r_sr + place(r_p_sr, w_kp);
                    n_si = r_si + place(r_p_si, w_kp);
                    n_pp = r_pp + place(r_p_p, w_kp);
                end
                n_ph = r_ph + 3'd1;
                if (r_ph == 3'd4) n_state = B_STEP;
            end
            B_STEP: begin
                if (w_esc) begin
                    n_state = B_LSET;
                end else begin
                    n_zr = w_zr_next;
                    n_zi = w_zi_next;
                    n_n  = r_n + 16'd1;
                    n_ph = '0;
                    n_sr = '0;
                    n_si = '0;
                    n_pp = '0;
                    if ({1'b0, r_n} + 17'd1 >= {1'b0, r_lim}) n_state = B_LSET;
                    else n_state = B_MUL;
                end
            end
            B_LSET: begin
                n_dd    = 24'({8'd0, r_lim - r_n} * 24'd255);
                n_rem   = '0;
                n_dcnt  = '0;
                n_state = B_LDIV;
            end
            B_LDIV: begin
                if (w_dt >= {1'b0, r_lim}) begin
                    n_rem = w_dt - {1'b0, r_lim};
                    n_dd  = {r_dd[22:0], 1'b1};
                end else begin
                    n_rem = w_dt;
                    n_dd  = {r_dd[22:0], 1'b0};
                end
                n_dcnt = r_dcnt + 5'd1;
                if (r_dcnt == 5'd23) begin
                    n_level = n_dd[7:0];
                    n_state = B_COL1;
                end
            end
            B_COL1: begin
                n_cprod = 14'({6'd0, r_level} * {8'd0, 6'd60 - w_t});
                if (r_level >= 8'd240) n_sect = 3'd4;
                else if (r_level >= 8'd180) n_sect = 3'd3;
                else if (r_level >= 8'd120) n_sect = 3'd2;
                else if (r_level >= 8'd60) n_sect = 3'd1;
                else n_sect = 3'd0;
                n_state = B_COL2;
            end
            B_COL2: begin
                n_c_r = 8'd0;
                n_c_g = 8'd0;
                n_c_b = 8'd0;
                case (r_sect)
                    3'd0: begin n_c_r = r_level; n_c_g = w_x; end
                    3'd1: begin n_c_r = w_x; n_c_g = r_level; end
                    3'd2: begin n_c_g = r_level; n_c_b = w_x; end
                    3'd3: begin n_c_g = w_x; n_c_b = r_level; end
                    3'd4: begin n_c_r = w_x; n_c_b = r_level; end
                    default: begin n_c_r = r_level; n_c_b = w_x; end
                endcase
                n_state = B_HOLD;
            end
            B_HOLD: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_o_cnt  = r_n;
                    n_o_r    = r_c_r;
                    n_o_g    = r_c_g;
                    n_o_b    = r_c_b;
                    n_state  = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_cr    <= n_cr;
        r_ci    <= n_ci;
        r_zr    <= n_zr;
        r_zi    <= n_zi;
        r_n     <= n_n;
        r_lim   <= n_lim;
        r_ph    <= n_ph;
        r_p_sr  <= n_p_sr;
        r_p_si  <= n_p_si;
        r_p_p   <= n_p_p;
        r_sr    <= n_sr;
        r_si    <= n_si;
        r_pp    <= n_pp;
        r_dd    <= n_dd;
        r_rem   <= n_rem;
        r_dcnt  <= n_dcnt;
        r_level <= n_level;
        r_cprod <= n_cprod;
        r_sect  <= n_sect;
        r_o_cnt <= n_o_cnt;
        r_o_r   <= n_o_r;
        r_o_g   <= n_o_g;
        r_o_b   <= n_o_b;
        r_c_r   <= n_c_r;
        r_c_g   <= n_c_g;
        r_c_b   <= n_c_b;
    end

    assign o_out_valid    = r_ovalid;
    assign o_escape_count = r_o_cnt;
    assign o_red          = r_o_r;
    assign o_green        = r_o_g;
    assign o_blue         = r_o_b;
endmodule

@@ rtl/mandelbrot_escape_pixel.sv @@
// Mandelbrot escape-time pixel evaluator, top level.
// The front end maps a pixel by a 77-step serial divide by dim - 1 and takes no new pixel until it is pushed.
// Each loop pass consists of four 32x32 partial-product steps, an accumulate and the update.
// The front end can map later pixels into the queue while the back end iterates.
// While the output is stalled, the back end holds its finished pixel.
// Reset is synchronous and active low; it clears control state and loads the default window.
module mandelbrot_escape_pixel
    import mep_pkg::*;
#(
    parameter int MAX_DIM   = MEP_MAX_DIM,
    parameter int FRAC_BITS = MEP_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [11:0] i_pixel_col,
    input  logic [11:0] i_pixel_row,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_escape_count,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    logic [63:0] r_min_real, r_max_real, r_min_imag, r_max_imag;
    logic [12:0] r_width, r_height;
    logic [15:0] r_lim;

    t_q_stat w_q_stat;
    t_coord  w_push_data, w_pop_data;
    logic    w_push, w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_real <= 64'hE000_0000_0000_0000;
            r_max_real <= 64'h1000_0000_0000_0000;
            r_min_imag <= 64'hE800_0000_0000_0000;
            r_max_imag <= 64'h1800_0000_0000_0000;
            r_width    <= 13'd2160;
            r_height   <= 13'd2160;
            r_lim      <= 16'd1000;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MIN_REAL: r_min_real <= i_cfg_data;
                CFG_MAX_REAL: r_max_real <= i_cfg_data;
                CFG_MIN_IMAG: r_min_imag <= i_cfg_data;
                CFG_MAX_IMAG: r_max_imag <= i_cfg_data;
                CFG_WIDTH:    r_width    <= i_cfg_data[12:0];
                CFG_HEIGHT:   r_height   <= i_cfg_data[12:0];
                CFG_ITER_LIM: r_lim      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    mep_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pixel_col    (i_pixel_col),
        .i_pixel_row    (i_pixel_row),
        .i_min_real     (r_min_real),
        .i_max_real     (r_max_real),
        .i_min_imag     (r_min_imag),
        .i_max_imag     (r_max_imag),
        .i_image_width  (r_width),
        .i_image_height (r_height),
        .i_q_stat       (w_q_stat),
        .o_push         (w_push),
        .o_coord        (w_push_data)
    );

    mep_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_stat  (w_q_stat)
    );

    mep_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_stat          (w_q_stat),
        .i_coord           (w_pop_data),
        .o_pop             (w_pop),
        .i_iteration_limit (r_lim),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_escape_count    (o_escape_count),
        .o_red             (o_red),
        .o_green           (o_green),
        .o_blue            (o_blue)
    );
endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the Mandelbrot escape-time pixel evaluator.
module testbench;
    import mep_pkg::*;

    typedef struct {
        logic [15:0] count;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_shade;

    typedef struct {
        int          win;
        logic [11:0] col;
        logic [11:0] row;
        bit          known;
        t_shade      shade;
    } t_vector;

    localparam logic [63:0] FIX_NEG4 = 64'hC000_0000_0000_0000;
    localparam logic [63:0] FIX_POS4 = 64'h4000_0000_0000_0000;
    localparam t_shade ESC0  = '{16'd0, 8'd63, 8'd0, 8'd255};
    localparam t_shade INSIDE_MAX = '{16'd65535, 8'd0, 8'd0, 8'd0};
    localparam t_shade ANY   = '{16'd0, 8'd0, 8'd0, 8'd0};
    localparam int    CYCLE_LIMIT = 4000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [11:0] i_pixel_col = '0;
    logic [11:0] i_pixel_row = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_escape_count;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;

    logic [63:0] re_lo, re_hi, im_lo, im_hi;
    logic [12:0] cols_cfg, rows_cfg;
    logic [15:0] limit_cfg;

    t_shade pending_shades[$];
    int     mismatches = 0;
    int     cycles = 0;
    int     idle_pct = 0;
    int     stall_pct = 0;
    int     cur_win;

    t_vector vectors[] = '{
        '{0, 12'd0,    12'd0,    1'b1, ESC0},
        '{0, 12'd4095, 12'd4095, 1'b1, ESC0},
        '{0, 12'd4095, 12'd0,    1'b1, ESC0},
        '{0, 12'd1439, 12'd1079, 1'b1, '{16'd1000, 8'd0, 8'd0, 8'd0}},
        '{0, 12'd2159, 12'd2159, 1'b0, ANY},
        '{0, 12'd400,  12'd1079, 1'b0, ANY},
        '{0, 12'd1000, 12'd1500, 1'b0, ANY},
        '{0, 12'd1200, 12'd700,  1'b0, ANY},
        '{0, 12'd1400, 12'd1300, 1'b0, ANY},
        '{0, 12'd2730, 12'd1365, 1'b0, ANY},
        '{1, 12'd0,    12'd0,    1'b1, ESC0},
        '{1, 12'd1,    12'd1,    1'b1, ESC0},
        '{1, 12'd4095, 12'd4095, 1'b1, ESC0},
        '{1, 12'd0,    12'd2048, 1'b0, ANY},
        '{2, 12'd2048, 12'd0,    1'b0, ANY},
        '{2, 12'd4095, 12'd4095, 1'b1, ESC0},
        '{2, 12'd0,    12'd1,    1'b1, ESC0},
        '{2, 12'd2047, 12'd3000, 1'b0, ANY},
        '{3, 12'd1,    12'd1,    1'b1, INSIDE_MAX}
    };

    mandelbrot_escape_pixel u_top (.*);

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_shade want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_shades.size() == 0) begin
                $display("%0t: unexpected word count=%0d rgb=%0d,%0d,%0d", $time,
                         o_escape_count, o_red, o_green, o_blue);
                mismatches++;
            end else begin
                want = pending_shades.pop_front();
                if (want.count !== o_escape_count || want.red !== o_red ||
                    want.green !== o_green || want.blue !== o_blue) begin
                    $display("%0t: expected count=%0d rgb=%0d,%0d,%0d actual count=%0d rgb=%0d,%0d,%0d",
                             $time, want.count, want.red, want.green, want.blue,
                             o_escape_count, o_red, o_green, o_blue);
                    mismatches++;
                end
            end
        end
    end

    function automatic logic [63:0] map_axis(logic [63:0] lo, logic [63:0] hi,
                                             logic [11:0] idx, logic [12:0] dim);
        logic [127:0] span, mag, quo, sum;
        int unsigned  d;
        d = (dim < 2) ? 2 : (dim > MEP_MAX_DIM) ? MEP_MAX_DIM : dim;
        span = {{64{hi[63]}}, hi} - {{64{lo[63]}}, lo};
        mag = span[127] ? -span : span;
        quo = (mag * {116'd0, idx}) / (d - 1);
        if (span[127])
            quo = -quo;
        sum = {{64{lo[63]}}, lo} + quo;
        if (sum[127:63] == '0 || sum[127:63] == '1)
            return sum[63:0];
        return sum[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    endfunction

    function automatic t_shade shade_pixel(logic [11:0] col, logic [11:0] row);
        logic [63:0]         cr, ci, zr, zi;
        logic signed [127:0] sr, si, prod;
        logic [127:0]        diff, twice;
        int unsigned         n, lim, level, q, t, x, r, g, b;
        t_shade              s;
        cr = map_axis(re_lo, re_hi, col, cols_cfg);
        ci = map_axis(im_lo, im_hi, row, rows_cfg);
        zr = cr;
        zi = ci;
        n = 0;
        lim = (limit_cfg == 0) ? 1 : limit_cfg;
        while (n < lim) begin
            sr = $signed({{64{zr[63]}}, zr}) * $signed({{64{zr[63]}}, zr});
            si = $signed({{64{zi[63]}}, zi}) * $signed({{64{zi[63]}}, zi});
            if ($unsigned(sr + si) > (128'd1 << (2 * MEP_FRAC_BITS + 2)))
                break;
            prod = $signed({{64{zr[63]}}, zr}) * $signed({{64{zi[63]}}, zi});
            diff = sr - si;
            twice = prod + prod;
            zr = diff[MEP_FRAC_BITS +: 64] + cr;
            zi = twice[MEP_FRAC_BITS +: 64] + ci;
            n++;
        end
        level = 255 * (lim - n) / lim;
        q = level % 120;
        t = (q > 60) ? q - 60 : 60 - q;
        x = level * (60 - t) / 60;
        r = 0;
        g = 0;
        b = 0;
        case (level / 60)
            0: begin r = level; g = x; end
            1: begin r = x; g = level; end
            2: begin g = level; b = x; end
            3: begin g = x; b = level; end
            4: begin r = x; b = level; end
            default: begin r = level; b = x; end
        endcase
        s.count = n[15:0];
        s.red = r[7:0];
        s.green = g[7:0];
        s.blue = b[7:0];
        return s;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [63:0] value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = value;
        @(posedge i_clk);
        case (idx)
            CFG_MIN_REAL: re_lo = value;
            CFG_MAX_REAL: re_hi = value;
            CFG_MIN_IMAG: im_lo = value;
            CFG_MAX_IMAG: im_hi = value;
            CFG_WIDTH:    cols_cfg = value[12:0];
            CFG_HEIGHT:   rows_cfg = value[12:0];
            CFG_ITER_LIM: limit_cfg = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_window(logic [63:0] rl, logic [63:0] rh, logic [63:0] il,
                              logic [63:0] ih, logic [12:0] w, logic [12:0] h,
                              logic [15:0] lim);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_shades.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        write_reg(CFG_MIN_REAL, rl);
        write_reg(CFG_MAX_REAL, rh);
        write_reg(CFG_MIN_IMAG, il);
        write_reg(CFG_MAX_IMAG, ih);
        write_reg(CFG_WIDTH, {51'd0, w});
        write_reg(CFG_HEIGHT, {51'd0, h});
        write_reg(CFG_ITER_LIM, {48'd0, lim});
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_pixel(logic [11:0] col, logic [11:0] row, bit known, t_shade shade);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_pixel_col = col;
        i_pixel_row = row;
        do
            @(posedge i_clk);
        while (o_in_stall);
        pending_shades.push_back(known ? shade : shade_pixel(col, row));
    endtask

    function automatic logic [63:0] rand_edge();
        logic [63:0] v;
        v = {$urandom, $urandom};
        if ($urandom_range(9) == 0)
            return v;
        return $signed(v) >>> 2;
    endfunction

    initial begin
        logic [12:0] w, h;
        logic [11:0] c, r;
        re_lo = 64'hE000_0000_0000_0000;
        re_hi = 64'h1000_0000_0000_0000;
        im_lo = 64'hE800_0000_0000_0000;
        im_hi = 64'h1800_0000_0000_0000;
        cols_cfg = 13'd2160;
        rows_cfg = 13'd2160;
        limit_cfg = 16'd1000;
        cur_win = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (vectors[k]) begin
            if (vectors[k].win != cur_win) begin
                cur_win = vectors[k].win;
                case (cur_win)
                    1: set_window(FIX_NEG4, FIX_POS4, FIX_NEG4, FIX_POS4, 13'd0, 13'd8191, 16'd0);
                    2: set_window(FIX_POS4, FIX_NEG4, 64'd0, 64'd0, 13'd4097, 13'd2, 16'd20);
                    default: set_window(FIX_NEG4, FIX_POS4, FIX_NEG4, FIX_POS4, 13'd3, 13'd3,
                                        16'd65535);
                endcase
            end
            send_pixel(vectors[k].col, vectors[k].row, vectors[k].known, vectors[k].shade);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 80; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            for (int sub = 0; sub < 3; sub++) begin
                w = ($urandom_range(3) == 0) ? 13'($urandom) : 13'($urandom_range(2, 80));
                h = ($urandom_range(3) == 0) ? 13'($urandom) : 13'($urandom_range(2, 80));
                set_window(rand_edge(), rand_edge(), rand_edge(), rand_edge(), w, h,
                           16'($urandom_range(0, 48)));
                for (int k = 0; k < 50; k++) begin
                    if ($urandom_range(9) < 7 && cols_cfg > 1 && rows_cfg > 1) begin
                        c = 12'($urandom_range(((cols_cfg > MEP_MAX_DIM) ? MEP_MAX_DIM
                                                                         : cols_cfg) - 1));
                        r = 12'($urandom_range(((rows_cfg > MEP_MAX_DIM) ? MEP_MAX_DIM
                                                                         : rows_cfg) - 1));
                    end else begin
                        c = 12'($urandom);
                        r = 12'($urandom);
                    end
                    send_pixel(c, r, 1'b0, ANY);
                end
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_shades.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
